>>> rtl/bced_pkg.sv
// ----------------------------------------------------------------------------
// bced_pkg: shared constants, types and helpers
// Geometry limits, register codes, mode decode and the structs passed
// between the window stages, the output queue and the top level.
// ----------------------------------------------------------------------------
package bced_pkg;

    // Line store geometry
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WEFF_W     = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W      = 12;
    localparam int HEFF_W     = 13;

    // Configuration port
    localparam int CFG_WIDTH_W  = 11;
    localparam int CFG_HEIGHT_W = 13;
    localparam int CFG_MODE_W   = 2;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_IDX_W    = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MODE   = 2'd2;

    localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RST  = 11'd640;
    localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RST = 13'd480;
    localparam logic [CFG_MODE_W-1:0]   MODE_RST   = 2'd0;

    // Raw op_mode codes
    localparam logic [CFG_MODE_W-1:0] OPM_ERODE  = 2'd0;
    localparam logic [CFG_MODE_W-1:0] OPM_DILATE = 2'd1;

    // Output queue
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [1:0] {
        MODE_ERODE,
        MODE_DILATE,
        MODE_OPEN
    } mode_t;

    typedef struct packed {
        logic go;
        logic flush;
        logic pix;
    } stage_req_t;

    typedef struct packed {
        logic valid;
        logic value;
        logic last;
    } stage_res_t;

    typedef struct packed {
        logic pixel;
        logic last;
    } out_item_t;

    // Mode three behaves as open
    function automatic mode_t decode_mode(input logic [CFG_MODE_W-1:0] m);
        mode_t r;
        if (m[1])
        begin
            r = MODE_OPEN;
        end
        else if (m == OPM_DILATE)
        begin
            r = MODE_DILATE;
        end
        else
        begin
            r = MODE_ERODE;
        end
        return r;
    endfunction

    function automatic logic [WEFF_W-1:0] clamp_width(input logic [CFG_WIDTH_W-1:0] w);
        logic [WEFF_W-1:0] r;
        if (w == '0)
        begin
            r = WEFF_W'(1);
        end
        else if (32'(w) > MAX_WIDTH)
        begin
            r = WEFF_W'(MAX_WIDTH);
        end
        else
        begin
            r = WEFF_W'(w);
        end
        return r;
    endfunction

    function automatic logic [HEFF_W-1:0] clamp_height(input logic [CFG_HEIGHT_W-1:0] h);
        logic [HEFF_W-1:0] r;
        if (h == '0)
        begin
            r = HEFF_W'(1);
        end
        else if (32'(h) > MAX_HEIGHT)
        begin
            r = HEFF_W'(MAX_HEIGHT);
        end
        else
        begin
            r = HEFF_W'(h);
        end
        return r;
    endfunction

endpackage

>>> rtl/bced_ram.sv
// ----------------------------------------------------------------------------
// bced_ram: generic synchronous RAM
// One write port, two read ports, read data registered (old data on a
// read of the address being written).
// ----------------------------------------------------------------------------
module bced_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH)-1:0]         waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH)-1:0]         raddr_a,
    input  logic [$clog2(DEPTH)-1:0]         raddr_b,
    output logic [WIDTH-1:0]                 rdata_a,
    output logic [WIDTH-1:0]                 rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

>>> rtl/bced_stage.sv
// ----------------------------------------------------------------------------
// bced_stage: one cross-window filter stage
// Two line store banks (even and odd rows), input and output raster
// counters; the window result comes in the cycle after the item that triggers it.
// ----------------------------------------------------------------------------
module bced_stage (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          dil,
    input  bced_pkg::stage_req_t          req,
    input  logic [bced_pkg::WEFF_W-1:0]   width,
    input  logic [bced_pkg::HEFF_W-1:0]   height,
    output bced_pkg::stage_res_t          res
);

    typedef struct packed {
        logic par;
        logic has_above;
        logic has_left;
        logic has_right;
        logic has_below;
        logic use_pix;
        logic pix;
    } ctx_t;

    logic [bced_pkg::ROW_W-1:0] in_row_reg, in_row_next;
    logic [bced_pkg::COL_W-1:0] in_col_reg, in_col_next;
    logic [bced_pkg::ROW_W-1:0] out_row_reg, out_row_next;
    logic [bced_pkg::COL_W-1:0] out_col_reg, out_col_next;
    logic                       in_done_reg, in_done_next;
    logic                       emit_reg, last_reg;
    ctx_t                       ctx_reg, ctx_next;
    logic                       left_reg;

    logic [bced_pkg::WEFF_W-1:0] in_col_inc, out_col_inc;
    logic [bced_pkg::HEFF_W-1:0] in_row_inc, out_row_inc, row_adv;
    logic                        accept_pix, emit, frame_done;
    logic [bced_pkg::COL_W-1:0]  right_addr;

    logic we0, we1;
    logic rd0_a, rd0_b, rd1_a, rd1_b;
    logic center, right, other, below, value;

    assign in_col_inc  = bced_pkg::WEFF_W'(in_col_reg) + bced_pkg::WEFF_W'(1);
    assign out_col_inc = bced_pkg::WEFF_W'(out_col_reg) + bced_pkg::WEFF_W'(1);
    assign in_row_inc  = bced_pkg::HEFF_W'(in_row_reg) + bced_pkg::HEFF_W'(1);
    assign out_row_inc = bced_pkg::HEFF_W'(out_row_reg) + bced_pkg::HEFF_W'(1);

    assign accept_pix = req.go && !req.flush && !in_done_reg;
    assign emit = (accept_pix && (in_row_reg != '0)) || (req.go && req.flush && in_done_reg);

    // right neighbor column, kept inside the store
    assign right_addr = (out_col_inc >= bced_pkg::WEFF_W'(bced_pkg::MAX_WIDTH)) ?
                        '0 : bced_pkg::COL_W'(out_col_inc);

    assign we0 = accept_pix && !in_row_reg[0];
    assign we1 = accept_pix && in_row_reg[0];

    bced_ram #(.WIDTH(1), .DEPTH(bced_pkg::MAX_WIDTH)) u_bank0 (
        .clk     (clk),
        .we      (we0),
        .waddr   (in_col_reg),
        .wdata   (req.pix),
        .raddr_a (out_col_reg),
        .raddr_b (right_addr),
        .rdata_a (rd0_a),
        .rdata_b (rd0_b)
    );

    bced_ram #(.WIDTH(1), .DEPTH(bced_pkg::MAX_WIDTH)) u_bank1 (
        .clk     (clk),
        .we      (we1),
        .waddr   (in_col_reg),
        .wdata   (req.pix),
        .raddr_a (out_col_reg),
        .raddr_b (right_addr),
        .rdata_a (rd1_a),
        .rdata_b (rd1_b)
    );

    always_comb
    begin
        in_row_next  = in_row_reg;
        in_col_next  = in_col_reg;
        out_row_next = out_row_reg;
        out_col_next = out_col_reg;
        in_done_next = in_done_reg;
        row_adv      = bced_pkg::HEFF_W'(out_row_reg);
        frame_done   = 1'b0;

        if (accept_pix)
        begin
            if (in_col_inc >= width)
            begin
                in_col_next = '0;
                in_row_next = bced_pkg::ROW_W'(in_row_inc);
                if (in_row_inc >= height)
                begin
                    in_done_next = 1'b1;
                end
            end
            else
            begin
                in_col_next = bced_pkg::COL_W'(in_col_inc);
            end
        end

        if (emit)
        begin
            if (out_col_inc >= width)
            begin
                out_col_next = '0;
                row_adv      = out_row_inc;
            end
            else
            begin
                out_col_next = bced_pkg::COL_W'(out_col_inc);
            end
            out_row_next = bced_pkg::ROW_W'(row_adv);
            if (row_adv >= height)
            begin
                frame_done = 1'b1;
            end
        end

        // last pixel of the frame: clear every counter
        if (frame_done)
        begin
            in_row_next  = '0;
            in_col_next  = '0;
            out_row_next = '0;
            out_col_next = '0;
            in_done_next = 1'b0;
        end
    end

    always_comb
    begin
        ctx_next.par       = out_row_reg[0];
        ctx_next.has_above = (out_row_reg != '0);
        ctx_next.has_left  = (out_col_reg != '0);
        ctx_next.has_right = (out_col_inc < width);
        ctx_next.has_below = (out_row_inc < height);
        ctx_next.use_pix   = !req.flush;
        ctx_next.pix       = req.pix;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_row_reg  <= '0;
            in_col_reg  <= '0;
            out_row_reg <= '0;
            out_col_reg <= '0;
            in_done_reg <= 1'b0;
            emit_reg    <= 1'b0;
            last_reg    <= 1'b0;
        end
        else
        begin
            in_row_reg  <= in_row_next;
            in_col_reg  <= in_col_next;
            out_row_reg <= out_row_next;
            out_col_reg <= out_col_next;
            in_done_reg <= in_done_next;
            emit_reg    <= emit;
            last_reg    <= emit && frame_done;
        end
    end

    always_ff @(posedge clk)
    begin
        ctx_reg <= ctx_next;
        if (emit_reg)
        begin
            left_reg <= center;
        end
    end

    // window evaluation on the registered read data
    always_comb
    begin
        center = ctx_reg.par ? rd1_a : rd0_a;
        right  = ctx_reg.par ? rd1_b : rd0_b;
        other  = ctx_reg.par ? rd0_a : rd1_a;
        below  = ctx_reg.use_pix ? ctx_reg.pix : other;
        if (dil)
        begin
            value = center
                  | (ctx_reg.has_above & other)
                  | (ctx_reg.has_left  & left_reg)
                  | (ctx_reg.has_right & right)
                  | (ctx_reg.has_below & below);
        end
        else
        begin
            value = center
                  & (!ctx_reg.has_above | other)
                  & (!ctx_reg.has_left  | left_reg)
                  & (!ctx_reg.has_right | right)
                  & (!ctx_reg.has_below | below);
        end
    end

    assign res.valid = emit_reg;
    assign res.value = value;
    assign res.last  = last_reg;

endmodule

>>> rtl/bced_out_fifo.sv
// ----------------------------------------------------------------------------
// bced_out_fifo: result queue
// Small register queue that decouples the filter pipeline from the
// downstream stall; reports its fill level for input credit.
// ----------------------------------------------------------------------------
module bced_out_fifo (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  bced_pkg::out_item_t          push_item,
    input  logic                         out_stall,
    output logic                         out_valid,
    output logic                         pixel_out,
    output logic                         frame_end,
    output logic [bced_pkg::CNT_W-1:0]   count
);

    bced_pkg::out_item_t              mem_reg [bced_pkg::FIFO_DEPTH];
    logic [bced_pkg::PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [bced_pkg::PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [bced_pkg::CNT_W-1:0]       count_reg, count_next;
    logic                             pop;

    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && !out_stall;
    assign pixel_out = mem_reg[rd_ptr_reg].pixel;
    assign frame_end = mem_reg[rd_ptr_reg].last;
    assign count     = count_reg;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + bced_pkg::PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + bced_pkg::PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + bced_pkg::CNT_W'(push) - bced_pkg::CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> rtl/binary_cross_erode_dilate.sv
// ----------------------------------------------------------------------------
// binary_cross_erode_dilate: 4-neighbor binary erosion, dilation and opening
// Path: each result passes the p1_reg and p2_reg registers and then the result queue (erode, dilate and open).
// Throughput: one item per cycle while in_stall is low; each stage does at most one line store read pair
//   and one write per item, and the result queue absorbs downstream stalls.
// Reset: geometry 640x480, erode mode, all counters and the queue clear;
//   line stores are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module binary_cross_erode_dilate (
    input  logic                                clk,
    input  logic                                rst_n,
    // input items
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                cmd,
    input  logic                                pixel_in,
    // result items
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                pixel_out,
    output logic                                frame_end,
    // configuration writes
    input  logic                                cfg_we,
    input  logic [bced_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bced_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // Pipeline: item enters the erode stage in its accept cycle, the dilate
    // stage in the following cycle, and the result is queued after that.
    typedef struct packed {
        logic            valid;
        bced_pkg::mode_t mode;
        logic            cmd;
        logic            pix;
    } p1_t;

    typedef struct packed {
        logic                 valid;
        bced_pkg::mode_t      mode;
        bced_pkg::stage_res_t s0;
    } p2_t;

    logic [bced_pkg::CFG_WIDTH_W-1:0]  image_width_reg;
    logic [bced_pkg::CFG_HEIGHT_W-1:0] image_height_reg;
    logic [bced_pkg::CFG_MODE_W-1:0]   op_mode_reg;

    logic [bced_pkg::WEFF_W-1:0]       eff_width;
    logic [bced_pkg::HEFF_W-1:0]       eff_height;
    bced_pkg::mode_t                   mode;

    p1_t                               p1_reg, p1_next;
    p2_t                               p2_reg, p2_next;

    bced_pkg::stage_req_t              s0_req, s1_req;
    bced_pkg::stage_res_t              s0_res, s1_res;

    logic                              in_accept;
    logic                              push;
    bced_pkg::out_item_t               push_item;
    logic [bced_pkg::CNT_W-1:0]        fifo_count;
    logic [bced_pkg::CNT_W:0]          pending;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= bced_pkg::WIDTH_RST;
            image_height_reg <= bced_pkg::HEIGHT_RST;
            op_mode_reg      <= bced_pkg::MODE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bced_pkg::CFG_IDX_WIDTH:
                begin
                    image_width_reg <= cfg_data[bced_pkg::CFG_WIDTH_W-1:0];
                end
                bced_pkg::CFG_IDX_HEIGHT:
                begin
                    image_height_reg <= cfg_data[bced_pkg::CFG_HEIGHT_W-1:0];
                end
                bced_pkg::CFG_IDX_MODE:
                begin
                    op_mode_reg <= cfg_data[bced_pkg::CFG_MODE_W-1:0];
                end
                default:
                begin
                    // unused index: drop the write
                end
            endcase
        end
    end

    // Saturate the geometry; a zero size acts as one
    assign eff_width  = bced_pkg::clamp_width(image_width_reg);
    assign eff_height = bced_pkg::clamp_height(image_height_reg);
    assign mode       = bced_pkg::decode_mode(op_mode_reg);

    // ------------------------------------------------------------------
    // Input credit: every item in flight may still yield one result, so
    // hold the input while queue plus pipeline could fill the queue.
    // ------------------------------------------------------------------
    assign pending   = (bced_pkg::CNT_W+1)'(fifo_count)
                     + (bced_pkg::CNT_W+1)'(p1_reg.valid)
                     + (bced_pkg::CNT_W+1)'(p2_reg.valid);
    assign in_stall  = (pending >= (bced_pkg::CNT_W+1)'(bced_pkg::FIFO_DEPTH));
    assign in_accept = in_valid && !in_stall;

    // ------------------------------------------------------------------
    // Erode stage: sees the item in its accept cycle
    // ------------------------------------------------------------------
    assign s0_req.go    = in_accept && (mode != bced_pkg::MODE_DILATE);
    assign s0_req.flush = cmd;
    assign s0_req.pix   = pixel_in;

    bced_stage u_erode (
        .clk    (clk),
        .rst_n  (rst_n),
        .dil    (1'b0),
        .req    (s0_req),
        .width  (eff_width),
        .height (eff_height),
        .res    (s0_res)
    );

    always_comb
    begin
        p1_next.valid = in_accept;
        p1_next.mode  = mode;
        p1_next.cmd   = cmd;
        p1_next.pix   = pixel_in;
    end

    // ------------------------------------------------------------------
    // Dilate stage: in the cycle after the accept. In open mode it takes the
    // erode result as a pixel, or a flush that the erode stage did not use.
    // ------------------------------------------------------------------
    always_comb
    begin
        s1_req.go    = 1'b0;
        s1_req.flush = p1_reg.cmd;
        s1_req.pix   = p1_reg.pix;
        case (p1_reg.mode)
            bced_pkg::MODE_OPEN:
            begin
                s1_req.go    = p1_reg.valid && (s0_res.valid || p1_reg.cmd);
                s1_req.flush = !s0_res.valid;
                s1_req.pix   = s0_res.value;
            end
            bced_pkg::MODE_DILATE:
            begin
                s1_req.go = p1_reg.valid;
            end
            default:
            begin
                s1_req.go = 1'b0;
            end
        endcase
    end

    bced_stage u_dilate (
        .clk    (clk),
        .rst_n  (rst_n),
        .dil    (1'b1),
        .req    (s1_req),
        .width  (eff_width),
        .height (eff_height),
        .res    (s1_res)
    );

    always_comb
    begin
        p2_next.valid = p1_reg.valid;
        p2_next.mode  = p1_reg.mode;
        p2_next.s0    = s0_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_reg <= '0;
            p2_reg <= '0;
        end
        else
        begin
            p1_reg <= p1_next;
            p2_reg <= p2_next;
        end
    end

    // ------------------------------------------------------------------
    // Result select: erode-only results were held in p2_reg to line up
    // with the dilate stage output.
    // ------------------------------------------------------------------
    always_comb
    begin
        if (p2_reg.mode == bced_pkg::MODE_ERODE)
        begin
            push            = p2_reg.valid && p2_reg.s0.valid;
            push_item.pixel = p2_reg.s0.value;
            push_item.last  = p2_reg.s0.last;
        end
        else
        begin
            push            = p2_reg.valid && s1_res.valid;
            push_item.pixel = s1_res.value;
            push_item.last  = s1_res.last;
        end
    end

    bced_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .pixel_out (pixel_out),
        .frame_end (frame_end),
        .count     (fifo_count)
    );

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Credit must keep the queue from overflowing
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> ((fifo_count < bced_pkg::CNT_W'(bced_pkg::FIFO_DEPTH))
                  || (out_valid && !out_stall)))
        else $error("result queue overflow");

    // A queued result always stems from an item accepted into p1_reg and passed on to p2_reg
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> $past(in_accept, 2))
        else $error("result without a matching item");

    // The erode stage only answers an item from the previous cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        s0_res.valid |-> $past(in_accept))
        else $error("erode stage result without an item");

endmodule
